@@ src/murmurhash2_stream_macros.svh @@
// ----------------------------------------------------------------------------
// murmurhash2 stream assertion macros
// shared concurrent assertion forms, clocked on clk with async reset
// ----------------------------------------------------------------------------
`ifndef MURMURHASH2_STREAM_MACROS_SVH
`define MURMURHASH2_STREAM_MACROS_SVH

// same-cycle implication
`define MH2_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MH2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mh2_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_pkg
// constants, queue entry type and multiply helper for the hash stream
// ----------------------------------------------------------------------------
package mh2_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'h0000_0da0;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_FULL = 2'd1,
		OP_TAIL = 2'd2
	} op_t;

	// one classified word on its way to the hash recurrence
	typedef struct packed {
		logic [31:0] key;
		op_t         op;
		logic [31:0] len;
		logic        last;
	} item_t;

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

endpackage

@@ src/mh2_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_front
// accepts words, classifies them and premixes full keys in three stages
// ----------------------------------------------------------------------------
module mh2_front #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             data_valid,
	output logic                             data_stall,
	input  logic [31:0]                      data_word,
	input  logic [2:0]                       valid_bytes,
	input  logic [31:0]                      total_length,
	input  logic                             last_word,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
	output logic                             push,
	output mh2_pkg::item_t                   push_item
);
	import mh2_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic        v_s1, v_s2, v_s3;
	item_t       it_s1, it_s2, it_s3;
	logic        accept;
	op_t         op_in;
	logic [31:0] masked;
	logic [31:0] k_mid;
	logic [CW:0] credit_need;

	// a request is only taken when the queue has room for everything in flight
	assign credit_need = {1'b0, q_count} + (CW+1)'(v_s1) + (CW+1)'(v_s2) + (CW+1)'(v_s3);
	assign data_stall  = credit_need >= (CW+1)'(QUEUE_DEPTH);
	assign accept      = data_valid && !data_stall;

	always_comb begin
		masked = data_word;
		if (valid_bytes == 3'd0) begin
			op_in = OP_NONE;
		end else if (valid_bytes >= 3'd4) begin
			op_in = OP_FULL;
		end else begin
			op_in = OP_TAIL;
			unique case (valid_bytes)
				3'd1:    masked = data_word & 32'h0000_00ff;
				3'd2:    masked = data_word & 32'h0000_ffff;
				default: masked = data_word & 32'h00ff_ffff;
			endcase
		end
	end

	assign k_mid = it_s2.key ^ (it_s2.key >> MIX_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		it_s1.key  <= masked;
		it_s1.op   <= op_in;
		it_s1.len  <= total_length;
		it_s1.last <= last_word;

		it_s2.op   <= it_s1.op;
		it_s2.len  <= it_s1.len;
		it_s2.last <= it_s1.last;
		it_s2.key  <= (it_s1.op == OP_FULL) ? mul32(it_s1.key, MIX_MUL) : it_s1.key;

		it_s3.op   <= it_s2.op;
		it_s3.len  <= it_s2.len;
		it_s3.last <= it_s2.last;
		it_s3.key  <= (it_s2.op == OP_FULL) ? mul32(k_mid, MIX_MUL) : it_s2.key;
	end

	assign push      = v_s3;
	assign push_item = it_s3;

endmodule

@@ src/mh2_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_queue
// small register queue between the premix pipeline and the hash recurrence
// ----------------------------------------------------------------------------
`include "murmurhash2_stream_macros.svh"

module mh2_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  mh2_pkg::item_t                   push_item,
	input  logic                             pop,
	output logic                             q_nonempty,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
	output mh2_pkg::item_t                   head_item
);
	import mh2_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t         mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign q_nonempty = count_q != '0;
	assign q_count    = count_q;
	assign head_item  = mem[rd_ptr_q];

	`MH2_ASSERT_NOW(a_no_overflow, clk, arst_n, push, (count_q != CW'(QUEUE_DEPTH)) || pop, "queue overflow")
	`MH2_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, count_q != '0, "queue underflow")
	`MH2_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH), "queue count out of range")

endmodule

@@ src/mh2_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_back
// running hash recurrence, finalization mix and output register
// ----------------------------------------------------------------------------
`include "murmurhash2_stream_macros.svh"

module mh2_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seed_we,
	input  logic [31:0]    seed_wdata,
	input  logic           q_nonempty,
	input  mh2_pkg::item_t head_item,
	output logic           pop,
	output logic           hash_valid,
	input  logic           hash_stall,
	output logic [31:0]    hash_value
);
	import mh2_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] h_q;
	logic        in_msg_q;
	logic        fin_v_q;
	logic [31:0] fin_q;
	logic        out_v_q;
	logic [31:0] out_q;

	logic        fin_go;
	logic [31:0] base;
	logic [31:0] mul_a;
	logic [31:0] prod;
	logic [31:0] h_new;
	logic [31:0] fin_mix;
	logic [31:0] fin_prod;

	assign fin_go = fin_v_q && (!out_v_q || !hash_stall);
	assign pop    = q_nonempty && (!fin_v_q || fin_go);

	// first word of a message starts from seed xor length
	assign base  = in_msg_q ? h_q : (seed_q ^ head_item.len);
	assign mul_a = (head_item.op == OP_TAIL) ? (base ^ head_item.key) : base;
	assign prod  = mul32(mul_a, MIX_MUL);

	always_comb begin
		unique case (head_item.op)
			OP_FULL: h_new = prod ^ head_item.key;
			OP_TAIL: h_new = prod;
			default: h_new = base;
		endcase
	end

	assign fin_mix  = fin_q ^ (fin_q >> FIN_SHIFT_A);
	assign fin_prod = mul32(fin_mix, MIX_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SEED_RESET;
			h_q      <= '0;
			in_msg_q <= 1'b0;
			fin_v_q  <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			if (pop) begin
				if (head_item.last) begin
					h_q      <= '0;
					in_msg_q <= 1'b0;
				end else begin
					h_q      <= h_new;
					in_msg_q <= 1'b1;
				end
			end
			if (pop && head_item.last) begin
				fin_v_q <= 1'b1;
			end else if (fin_go) begin
				fin_v_q <= 1'b0;
			end
			if (fin_go) begin
				out_v_q <= 1'b1;
			end else if (!hash_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.last) begin
			fin_q <= h_new;
		end
		if (fin_go) begin
			out_q <= fin_prod ^ (fin_prod >> FIN_SHIFT_B);
		end
	end

	assign hash_valid = out_v_q;
	assign hash_value = out_q;

	`MH2_ASSERT_NOW(a_fin_not_lost, clk, arst_n, pop && fin_v_q, fin_go, "finaliser overwritten")
	`MH2_ASSERT_NEXT(a_msg_closed, clk, arst_n, pop && head_item.last, !in_msg_q && (h_q == '0), "hash not cleared after last word")
	`MH2_ASSERT_NEXT(a_out_from_fin, clk, arst_n, !out_v_q && !fin_v_q, !out_v_q, "result without finalisation")

endmodule

@@ src/murmurhash2_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmurhash2_stream
// 32-bit murmurhash2 of messages streamed as little-endian words
// ----------------------------------------------------------------------------
// usage:
//  - input channel data_valid/data_stall carries one word per request with
//    valid_bytes, total_length (sampled on a message's first word) and
//    last_word; an empty message is one last word with zero valid bytes
//  - output channel hash_valid/hash_stall carries one hash_value per message,
//    produced by its last word
//  - seed_we/seed_wdata writes the seed; write it only while the block is idle
//  - hash_valid rises once a last word passes premix, queue and finaliser
//  - throughput: one word per cycle unless stalled; a three-stage key premix
//    feeds a QUEUE_DEPTH-entry queue; the hash takes one multiply per cycle
//  - data_stall rises when the queue plus the premix stages would be full
//  - a stalled receiver holds the result register, then the finaliser, then
//    the queue, and finally the input side stalls
//  - reset clears all valid state and loads the seed with 0xda0
// ----------------------------------------------------------------------------
module murmurhash2_stream #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_wdata,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic [31:0] total_length,
	input  logic        last_word,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [31:0] hash_value
);
	import mh2_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          push;
	item_t         push_item;
	logic          pop;
	logic          q_nonempty;
	logic [CW-1:0] q_count;
	item_t         head_item;

	mh2_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.total_length(total_length),
		.last_word   (last_word),
		.q_count     (q_count),
		.push        (push),
		.push_item   (push_item)
	);

	mh2_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_nonempty(q_nonempty),
		.q_count   (q_count),
		.head_item (head_item)
	);

	mh2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed_wdata(seed_wdata),
		.q_nonempty(q_nonempty),
		.head_item (head_item),
		.pop       (pop),
		.hash_valid(hash_valid),
		.hash_stall(hash_stall),
		.hash_value(hash_value)
	);

endmodule

@@ sim/murmurhash2_stream_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmurhash2_stream_tb
// random and directed messages checked against an in-bench hash recurrence
// ----------------------------------------------------------------------------
// messages are queued by the stimulus block and sent in bursts by a clocked
// driver; each accepted word steps a local copy of the hash state, and every
// last word pushes its finalised hash. a clocked monitor stalls the result
// side on changing patterns and compares each hash in order. the seed is
// rewritten between phases once the block has drained.
// ----------------------------------------------------------------------------
module murmurhash2_stream_tb;

	import mh2_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PHASE_WORDS  = 380;
	localparam int unsigned MAX_PRINTS   = 40;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic [31:0] len;
		logic        last;
	} word_req_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        seed_we      = 1'b0;
	logic [31:0] seed_wdata   = '0;
	logic        data_valid   = 1'b0;
	logic        data_stall;
	logic [31:0] data_word    = '0;
	logic [2:0]  valid_bytes  = '0;
	logic [31:0] total_length = '0;
	logic        last_word    = 1'b0;
	logic        hash_valid;
	logic        hash_stall   = 1'b0;
	logic [31:0] hash_value;

	// local copy of the block state
	logic [31:0] model_seed = SEED_RESET;
	logic [31:0] model_hash = '0;
	logic        model_open = 1'b0;

	word_req_t   word_queue[$];
	logic [31:0] expected_hashes[$];

	int unsigned words_issued   = 0;
	int unsigned words_accepted = 0;
	int unsigned fail_count     = 0;
	int unsigned cycle_count    = 0;

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_mode;
	int unsigned mode_left;
	int unsigned stall_run;

	murmurhash2_stream DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_we      (seed_we),
		.seed_wdata   (seed_wdata),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.total_length (total_length),
		.last_word    (last_word),
		.hash_valid   (hash_valid),
		.hash_stall   (hash_stall),
		.hash_value   (hash_value)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] mix_full(input logic [31:0] h, input logic [31:0] k);
		k = k * MIX_MUL;
		k = k ^ (k >> MIX_SHIFT);
		k = k * MIX_MUL;
		return (h * MIX_MUL) ^ k;
	endfunction

	function automatic logic [31:0] mix_short(input logic [31:0] h, input logic [31:0] w,
			input logic [2:0] nbytes);
		logic [31:0] mask;
		case (nbytes)
			3'd1: mask = 32'h0000_00ff;
			3'd2: mask = 32'h0000_ffff;
			default: mask = 32'h00ff_ffff;
		endcase
		h = h ^ (w & mask);
		return h * MIX_MUL;
	endfunction

	function automatic logic [31:0] finish_hash(input logic [31:0] h);
		h = h ^ (h >> FIN_SHIFT_A);
		h = h * MIX_MUL;
		h = h ^ (h >> FIN_SHIFT_B);
		return h;
	endfunction

	// steps the local hash state by one accepted request
	task automatic predict_hash_word(input word_req_t req);
		logic [31:0] h;
		op_t         op;
		h  = model_open ? model_hash : (model_seed ^ req.len);
		op = (req.nbytes >= 3'd4) ? OP_FULL : (req.nbytes != 3'd0) ? OP_TAIL : OP_NONE;
		case (op)
			OP_FULL: h = mix_full(h, req.word);
			OP_TAIL: h = mix_short(h, req.word, req.nbytes);
			default: ;
		endcase
		if (req.last) begin
			expected_hashes.push_back(finish_hash(h));
			model_hash = '0;
			model_open = 1'b0;
		end else begin
			model_hash = h;
			model_open = 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what);
		if (fail_count < MAX_PRINTS)
			$display("%0t ns: %s", $realtime, what);
		fail_count++;
	endtask

	// sender: bursts of random length with random gaps, sometimes none, in between
	always @(posedge clk or negedge arst_n) begin
		word_req_t req;
		if (!arst_n) begin
			data_valid   <= 1'b0;
			data_word    <= '0;
			valid_bytes  <= '0;
			total_length <= '0;
			last_word    <= 1'b0;
			burst_left   = $urandom_range(24, 1);
			gap_left     = 0;
		end else begin
			if (data_valid && !data_stall) begin
				req = '{data_word, valid_bytes, total_length, last_word};
				predict_hash_word(req);
				words_accepted++;
			end
			if (!data_valid || !data_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					data_valid <= 1'b0;
				end else if (word_queue.size() > 0) begin
					req = word_queue.pop_front();
					data_valid   <= 1'b1;
					data_word    <= req.word;
					valid_bytes  <= req.nbytes;
					total_length <= req.len;
					last_word    <= req.last;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(24, 1);
						gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
					end
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches between free-running, random and long holds
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			hash_stall <= 1'b0;
			stall_mode = 0;
			mode_left  = 64;
			stall_run  = 0;
		end else begin
			if (hash_valid && !hash_stall) begin
				if (expected_hashes.size() == 0) begin
					report_mismatch($sformatf("unexpected hash %08h", hash_value));
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want)
						report_mismatch($sformatf("hash_value %08h, want %08h", hash_value, want));
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(3, 0);
				mode_left  = $urandom_range(256, 32);
			end else begin
				mode_left--;
			end
			if (stall_run > 0) begin
				stall_run--;
				hash_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: hash_stall <= 1'b0;
					1: hash_stall <= 1'($urandom_range(1, 0));
					2: hash_stall <= ($urandom_range(3, 0) == 0);
					default: begin
						if ($urandom_range(9, 0) == 0)
							stall_run = $urandom_range(40, 5);
						hash_stall <= (stall_run > 0);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_word(input logic [31:0] word, input logic [2:0] nbytes,
			input logic [31:0] len, input logic last);
		word_queue.push_back('{word, nbytes, len, last});
		words_issued++;
	endtask

	// message of nbytes bytes with random content, sometimes with a random length
	task automatic push_message(input int unsigned nbytes);
		int unsigned full_words;
		int unsigned tail;
		logic [31:0] len;
		full_words = nbytes / 4;
		tail       = nbytes % 4;
		len        = ($urandom_range(9, 0) == 0) ? $urandom : nbytes;
		if (nbytes == 0) begin
			push_word($urandom, 3'd0, len, 1'b1);
		end else begin
			for (int i = 0; i < full_words; i++)
				push_word($urandom, 3'd4, (i == 0) ? len : $urandom,
					(tail == 0) && (i == full_words - 1));
			if (tail != 0)
				push_word($urandom, tail[2:0], (full_words == 0) ? len : $urandom, 1'b1);
		end
	endtask

	// arbitrary byte counts, stray short words and early ends
	task automatic push_noise();
		int unsigned n;
		n = $urandom_range(6, 1);
		for (int i = 0; i < n; i++)
			push_word($urandom, 3'($urandom_range(7, 0)), $urandom,
				(i == n - 1) || ($urandom_range(9, 0) == 0));
	endtask

	task automatic wait_idle();
		while (words_accepted != words_issued || expected_hashes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		seed_we    <= 1'b1;
		seed_wdata <= value;
		@(posedge clk);
		seed_we    <= 1'b0;
		model_seed = value;
	endtask

	initial begin
		logic [31:0] seeds[5];
		int unsigned phase_end;
		int unsigned msg_count;
		int unsigned r;
		seeds[0] = 32'h0000_0000;
		seeds[1] = 32'hffff_ffff;
		seeds[2] = $urandom;
		seeds[3] = $urandom;
		seeds[4] = $urandom;
		msg_count = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty messages, word content must be ignored
		push_word(32'hffff_ffff, 3'd0, 32'h0000_0000, 1'b1);
		push_word(32'h0000_0000, 3'd0, 32'hffff_ffff, 1'b1);
		// single full words at the extremes, one with a wrong length
		push_word(32'hffff_ffff, 3'd4, 32'd4, 1'b1);
		push_word(32'h0000_0000, 3'd4, 32'd0, 1'b1);
		// lone tails, upper bytes must be masked
		push_word(32'hffff_ffff, 3'd1, 32'd1, 1'b1);
		push_word(32'hffff_ffff, 3'd2, 32'd2, 1'b1);
		push_word(32'hffff_ffff, 3'd3, 32'd3, 1'b1);
		// byte counts above four act as a full word
		push_word($urandom, 3'd5, 32'd4, 1'b1);
		push_word($urandom, 3'd6, 32'd4, 1'b1);
		push_word($urandom, 3'd7, 32'd4, 1'b1);
		// two words and a tail, later lengths ignored
		push_word(32'h0000_0000, 3'd4, 32'd11, 1'b0);
		push_word(32'hffff_ffff, 3'd4, 32'hffff_ffff, 1'b0);
		push_word(32'h8765_4321, 3'd3, 32'h0000_0000, 1'b1);
		// zero-byte word inside a message
		push_word($urandom, 3'd0, 32'd8, 1'b0);
		push_word($urandom, 3'd4, $urandom, 1'b0);
		push_word($urandom, 3'd4, $urandom, 1'b1);
		// short word before the end, message carries on
		push_word(32'hffff_ffff, 3'd2, 32'd6, 1'b0);
		push_word($urandom, 3'd4, $urandom, 1'b1);
		// length far from the bytes delivered
		push_word($urandom, 3'd4, 32'd100, 1'b1);

		foreach (seeds[p]) begin
			write_seed(seeds[p]);
			phase_end = words_issued + PHASE_WORDS;
			while (words_issued < phase_end) begin
				r = $urandom_range(99, 0);
				if (r < 60)
					push_message($urandom_range(16, 0));
				else if (r < 80)
					push_message($urandom_range(64, 17));
				else if (r < 85)
					push_message($urandom_range(200, 65));
				else
					push_noise();
				msg_count++;
				// stimulus holds off until every hash so far has come back
				if (msg_count % 40 == 39)
					wait_idle();
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
